>>> src/obbtp_pkg.sv
// Shared types and constants for the one-bit branch target predictor.
// Used by obbtp_table and by the top level; depends on nothing else.
package obbtp_pkg;

  // Item kinds selected by the opcode field.
  typedef enum logic {
    OP_PREDICT = 1'b0,
    OP_RESOLVE = 1'b1
  } op_e;

  // Instruction size and the shift that turns a word offset into bytes.
  localparam logic [31:0] PC_STEP   = 32'd4;
  localparam int unsigned OFF_SHIFT = 2;

  // Value held by every tag and target after reset.
  localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;

  // One table entry as seen on the read port.
  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] target;
    logic        pred;
  } tbl_entry_t;

  // Write request to the table; the index travels beside it.
  typedef struct packed {
    logic        tag_we;   // writes tag and target
    logic        pred_we;  // writes the prediction bit
    logic [31:0] tag;
    logic [31:0] target;
    logic        pred;
  } tbl_wr_t;

endpackage

>>> src/obbtp_table.sv
// Branch table storage: tag, target and prediction-bit memories with one
// registered read port, one write port and a clearing pass after reset.
// Depends on obbtp_pkg.
module obbtp_table #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned IdxW          = $clog2(TABLE_ENTRIES)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rd_en_i,
  input  logic [IdxW-1:0]         rd_idx_i,
  output obbtp_pkg::tbl_entry_t   rd_data_o,
  input  logic [IdxW-1:0]         wr_idx_i,
  input  obbtp_pkg::tbl_wr_t      wr_i,
  output logic                    ready_o
);
  import obbtp_pkg::*;

  logic [31:0] tag_mem  [TABLE_ENTRIES];
  logic [31:0] tgt_mem  [TABLE_ENTRIES];
  logic        pred_mem [TABLE_ENTRIES];

  logic            clr_q, clr_d;
  logic [IdxW-1:0] clr_cnt_q, clr_cnt_d;
  tbl_entry_t      rd_q;

  logic            tag_we, pred_we;
  logic [IdxW-1:0] widx;
  logic [31:0]     wtag, wtgt;
  logic            wpred;

  // Clearing pass: one entry per cycle from index zero up to the last one.
  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == IdxW'(TABLE_ENTRIES - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Write port: the clearing pass overrides normal updates.
  always_comb begin
    if (clr_q) begin
      tag_we  = 1'b1;
      pred_we = 1'b1;
      widx    = clr_cnt_q;
      wtag    = ADDR_RESET;
      wtgt    = ADDR_RESET;
      wpred   = 1'b0;
    end else begin
      tag_we  = wr_i.tag_we;
      pred_we = wr_i.pred_we;
      widx    = wr_idx_i;
      wtag    = wr_i.tag;
      wtgt    = wr_i.target;
      wpred   = wr_i.pred;
    end
  end

  // Memories: read-before-write, read data registered.
  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[widx] <= wtag;
      tgt_mem[widx] <= wtgt;
    end
    if (pred_we) begin
      pred_mem[widx] <= wpred;
    end
    if (rd_en_i) begin
      rd_q.tag    <= tag_mem[rd_idx_i];
      rd_q.target <= tgt_mem[rd_idx_i];
      rd_q.pred   <= pred_mem[rd_idx_i];
    end
  end

  assign rd_data_o = rd_q;
  assign ready_o   = ~clr_q;

  // The pass ends exactly after the last entry has been written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_q) |-> $past(clr_cnt_q) == IdxW'(TABLE_ENTRIES - 1))
    else $error("clearing pass ended early");

  // No normal write is requested while the pass owns the port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !(wr_i.tag_we || wr_i.pred_we))
    else $error("table write during clearing pass");

  // Reads are not issued before the table is valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !rd_en_i)
    else $error("table read during clearing pass");

endmodule

>>> src/one_bit_branch_target_predictor.sv
// Top level of the one-bit branch target predictor: lookup, resolve and
// forwarding logic around the table. Depends on obbtp_pkg and obbtp_table.
//
// A word is taken when start_i is high and busy_o is low. The table is read
// at that edge, the entry is examined and written back in the next cycle, and
// valid_o is registered from the execute stage, so the result is shown for one
// cycle. A new word may be started every cycle while busy_o is low; when a word
// reads the entry the previous word is writing, the new value is forwarded
// around the memory. After reset busy_o stays high while the table is cleared
// one entry per cycle. Results cannot be held off and must be taken in the
// cycle they are shown. TABLE_ENTRIES must be a power of two.
module one_bit_branch_target_predictor #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               opcode_i,
  input  logic [31:0]        pc_i,
  input  logic               pc_write_i,
  input  logic [3:0]         entry_index_i,
  input  logic               was_found_i,
  input  logic               was_predicted_taken_i,
  input  logic               actually_taken_i,
  input  logic [31:0]        fall_through_in_i,
  input  logic signed [15:0] branch_offset_i,
  output logic               valid_o,
  output logic               hit_found_o,
  output logic               predict_taken_o,
  output logic [3:0]         index_out_o,
  output logic [31:0]        next_pc_o,
  output logic               pc_changes_o,
  output logic [31:0]        fall_through_out_o,
  output logic               mispredict_o,
  output logic               flush_front_o,
  output logic               correct_hit_o
);
  import obbtp_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  logic            accept;
  logic            tbl_ready;
  logic [IdxW-1:0] rd_idx;
  tbl_entry_t      rd_data;
  tbl_wr_t         wr;

  // Execute stage registers.
  logic               s1_valid_q;
  op_e                s1_op_q;
  logic [31:0]        s1_pc_q;
  logic               s1_pcw_q;
  logic [IdxW-1:0]    s1_idx_q;
  logic               s1_found_q;
  logic               s1_pred_q;
  logic               s1_act_q;
  logic [31:0]        s1_ft_q;
  logic signed [15:0] s1_off_q;

  // Forwarding of the entry written while the next word reads it.
  logic       fwd_q, fwd_d;
  tbl_entry_t fwd_ent_q, fwd_ent_d;
  tbl_entry_t ent;

  // Result word, next value.
  logic        hit_d, ptaken_d, pcchg_d, misp_d, corr_d;
  logic [3:0]  idxo_d;
  logic [31:0] npc_d, fto_d;

  logic [31:0] pc_plus4;
  logic [31:0] computed;
  logic        tag_match;
  logic        redirect;
  logic [31:0] dest;

  // Output registers.
  logic        valid_q;
  logic        hit_q, ptaken_q, pcchg_q, misp_q, corr_q;
  logic [3:0]  idxo_q;
  logic [31:0] npc_q, fto_q;

  assign busy_o = ~tbl_ready;
  assign accept = start_i & ~busy_o;

  // Read index: fetch PC bits for a lookup, recorded index for a resolve.
  assign rd_idx = (op_e'(opcode_i) == OP_PREDICT) ? pc_i[IdxW+1:2]
                                                 : IdxW'(entry_index_i);

  obbtp_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IdxW         (IdxW)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_idx_i (rd_idx),
    .rd_data_o(rd_data),
    .wr_idx_i (s1_idx_q),
    .wr_i     (wr),
    .ready_o  (tbl_ready)
  );

  // Capture the accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      fwd_q      <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= op_e'(opcode_i);
      s1_pc_q    <= pc_i;
      s1_pcw_q   <= pc_write_i;
      s1_idx_q   <= rd_idx;
      s1_found_q <= was_found_i;
      s1_pred_q  <= was_predicted_taken_i;
      s1_act_q   <= actually_taken_i;
      s1_ft_q    <= fall_through_in_i;
      s1_off_q   <= branch_offset_i;
    end
    fwd_ent_q <= fwd_ent_d;
  end

  // Entry seen by the execute stage.
  assign ent = fwd_q ? fwd_ent_q : rd_data;

  assign pc_plus4  = s1_pc_q + PC_STEP;
  assign computed  = s1_ft_q + {{(32 - 16 - OFF_SHIFT){s1_off_q[15]}}, s1_off_q,
                                {OFF_SHIFT{1'b0}}};
  assign tag_match = (s1_pc_q == ent.tag);

  // Execute: build the result word and the table update.
  always_comb begin
    hit_d    = 1'b0;
    ptaken_d = 1'b0;
    idxo_d   = '0;
    npc_d    = s1_pc_q;
    pcchg_d  = 1'b0;
    fto_d    = '0;
    misp_d   = 1'b0;
    corr_d   = 1'b0;
    redirect = 1'b0;
    dest     = s1_pc_q;
    wr       = '0;
    case (s1_op_q)
      OP_PREDICT: begin
        hit_d    = tag_match;
        ptaken_d = tag_match & ent.pred;
        idxo_d   = 4'(s1_idx_q);
        fto_d    = pc_plus4;
        if (s1_pcw_q) begin
          npc_d   = (tag_match & ent.pred) ? ent.target : pc_plus4;
          pcchg_d = 1'b1;
        end
      end
      OP_RESOLVE: begin
        if (s1_found_q) begin
          wr.pred_we = s1_valid_q;
          wr.pred    = s1_act_q;
          if (s1_pred_q == s1_act_q) begin
            corr_d = 1'b1;
          end else begin
            redirect = 1'b1;
            dest     = s1_act_q ? ent.target : s1_ft_q;
          end
        end else if (s1_act_q) begin
          // A taken branch that missed the table takes over its entry.
          wr.tag_we  = s1_valid_q;
          wr.pred_we = s1_valid_q;
          wr.tag     = s1_ft_q - PC_STEP;
          wr.target  = computed;
          wr.pred    = 1'b1;
          redirect   = 1'b1;
          dest       = computed;
        end
        misp_d = redirect;
        if (redirect && s1_pcw_q) begin
          npc_d   = dest;
          pcchg_d = 1'b1;
        end
      end
      default: begin
        npc_d = s1_pc_q;
      end
    endcase
  end

  // Forward when the incoming word reads the entry being written now.
  always_comb begin
    fwd_d     = accept && (wr.tag_we || wr.pred_we) && (rd_idx == s1_idx_q);
    fwd_ent_d = ent;
    if (wr.tag_we) begin
      fwd_ent_d.tag    = wr.tag;
      fwd_ent_d.target = wr.target;
    end
    if (wr.pred_we) begin
      fwd_ent_d.pred = wr.pred;
    end
  end

  // Output registers: each result is shown for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      hit_q    <= hit_d;
      ptaken_q <= ptaken_d;
      idxo_q   <= idxo_d;
      npc_q    <= npc_d;
      pcchg_q  <= pcchg_d;
      fto_q    <= fto_d;
      misp_q   <= misp_d;
      corr_q   <= corr_d;
    end
  end

  assign valid_o            = valid_q;
  assign hit_found_o        = hit_q;
  assign predict_taken_o    = ptaken_q;
  assign index_out_o        = idxo_q;
  assign next_pc_o          = npc_q;
  assign pc_changes_o       = pcchg_q;
  assign fall_through_out_o = fto_q;
  assign mispredict_o       = misp_q;
  assign flush_front_o      = misp_q;
  assign correct_hit_o      = corr_q;

  // A result strobe always stems from an accepted word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, 2))
    else $error("result without an accepted word");

  // Forwarded data only comes from a word that was in execute.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> $past(s1_valid_q))
    else $error("forwarding without a writer");

  // A resolve is either correct or a redirect, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(mispredict_o && correct_hit_o))
    else $error("mispredict and correct hit together");

  // The PC is only written when the accepted word allowed it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && pc_changes_o) |-> $past(pc_write_i, 2))
    else $error("PC change without pc_write");

endmodule
